// ----- rtl/arfc_pkg.sv -----
// Shared types and constants for the audio rate and format converter.
package arfc_pkg;

    // Fixed field widths
    localparam int PHASE_W  = 18;
    localparam int TACC_W   = PHASE_W + 1;
    localparam int RATE_W   = 18;
    localparam int VOL_W    = 9;
    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 32;
    localparam int CFG_IDX_W = 2;

    // At most this many output frames per source frame.
    localparam int MAX_RUN   = 64;
    localparam int RUN_CNT_W = $clog2(MAX_RUN);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_RATE    = 2'd0,
        CFG_SOURCE_STEREO  = 2'd1,
        CFG_SOURCE_16BIT   = 2'd2,
        CFG_GAIN_PCT       = 2'd3
    } cfg_idx_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_RUN
    } state_t;

    // Current configuration as seen by the datapath
    typedef struct packed {
        logic [RATE_W-1:0] source_rate;
        logic              source_stereo;
        logic              source_sixteen_bit;
        logic [VOL_W-1:0]  gain_pct;
    } cfg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic emit;
        logic skip;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic t_ge_rate;
        logic last;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- rtl/arfc_cfg.sv -----
// Configuration register file for the audio rate and format converter.
module arfc_cfg
    import arfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg     = cfg_reg;

    // Decode the register index of a write transaction.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SOURCE_RATE:    cfg_next.source_rate        = cfg_data;
                CFG_SOURCE_STEREO:  cfg_next.source_stereo      = cfg_data[0];
                CFG_SOURCE_16BIT:   cfg_next.source_sixteen_bit = cfg_data[0];
                CFG_GAIN_PCT:       cfg_next.gain_pct           = cfg_data[VOL_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_rate        <= RATE_W'(48000);
            cfg_reg.source_stereo      <= 1'b1;
            cfg_reg.source_sixteen_bit <= 1'b1;
            cfg_reg.gain_pct           <= VOL_W'(100);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/arfc_ctrl.sv -----
// Controller state machine that sequences scaling and the output run.
module arfc_ctrl
    import arfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_RUN;
            ST_RUN:
            begin
                if (status.t_ge_rate)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.out_busy && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL:  cmd.mul = 1'b1;
            ST_DIV:  cmd.div = 1'b1;
            ST_RUN:
            begin
                if (status.t_ge_rate)
                begin
                    cmd.skip = 1'b1;
                end
                else
                begin
                    cmd.emit = !status.out_busy;
                end
            end
            default:
            begin
                in_ready = 1'b0;
                cmd      = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted frame always starts the scaling sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MUL))
        else $error("accepted frame did not start scaling");

    // A run never ends while a result is still stalled in front of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !status.t_ge_rate && status.out_busy)
        |=> (state_reg == ST_RUN))
        else $error("run left while output stalled");

    // The output run is only entered from the divide step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && $past(state_reg) != ST_RUN) |-> ($past(state_reg) == ST_DIV))
        else $error("run entered without scaling");

endmodule

// ----- rtl/arfc_datapath.sv -----
// Datapath: sample decode, volume scaling, phase accumulator and output register.
module arfc_datapath
    import arfc_pkg::*;
#(
    parameter int OUTPUT_RATE = 48000
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 status,
    input  logic [FRAME_W-1:0]         frame_bytes,
    input  logic                       first_frame,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] left_sample,
    output logic signed [SAMPLE_W-1:0] right_sample,
    output logic                       last_of_run
);

    localparam int PROD_W = SAMPLE_W + VOL_W + 1;
    localparam int MAG_W  = 24;
    localparam int RECIP_SHIFT = 31;
    // ceil(2^31 / 100); exact floor division for magnitudes below 2^24
    localparam logic [24:0] RECIP = 25'd21474837;
    localparam logic [TACC_W-1:0] RATE_T = TACC_W'(OUTPUT_RATE);

    // Divide a scaled product by 100 toward zero and saturate to 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] div_sat(input logic signed [PROD_W-1:0] p);
        logic              neg;
        logic [PROD_W-1:0] mag;
        logic [48:0]       prod;
        logic [17:0]       q;
        neg  = p[PROD_W-1];
        mag  = neg ? PROD_W'(-p) : PROD_W'(p);
        prod = mag[MAG_W-1:0] * RECIP;
        q    = prod[RECIP_SHIFT+17:RECIP_SHIFT];
        if (neg)
        begin
            div_sat = (q >= 18'd32768) ? 16'sh8000 : SAMPLE_W'(18'd0 - q);
        end
        else
        begin
            div_sat = (q > 18'd32767) ? 16'sh7fff : q[SAMPLE_W-1:0];
        end
    endfunction

    logic signed [SAMPLE_W-1:0] smp_l_reg, smp_r_reg;
    logic signed [PROD_W-1:0]   prod_l_reg, prod_r_reg;
    logic signed [SAMPLE_W-1:0] scl_l_reg, scl_r_reg;
    logic [TACC_W-1:0]          t_reg;
    logic [RUN_CNT_W-1:0]       n_reg;
    logic [PHASE_W-1:0]         phase_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] left_reg, right_reg;
    logic                       last_reg;

    logic signed [SAMPLE_W-1:0] dec_l, dec_r;
    logic [TACC_W-1:0]          t_sum;
    logic                       sum_ge_rate;
    logic                       last_now;
    logic                       out_valid_next;

    // Decode one source frame into left and right 16-bit samples.
    always_comb
    begin
        if (cfg.source_sixteen_bit)
        begin
            dec_l = frame_bytes[15:0];
            dec_r = cfg.source_stereo ? frame_bytes[31:16] : frame_bytes[15:0];
        end
        else
        begin
            dec_l = {~frame_bytes[7], frame_bytes[6:0], 8'h00};
            dec_r = cfg.source_stereo ? {~frame_bytes[15], frame_bytes[14:8], 8'h00}
                                      : {~frame_bytes[7], frame_bytes[6:0], 8'h00};
        end
    end

    // Phase step and end-of-run detection.
    assign t_sum       = t_reg + TACC_W'(cfg.source_rate);
    assign sum_ge_rate = (t_sum >= RATE_T);
    assign last_now    = sum_ge_rate || (n_reg == RUN_CNT_W'(MAX_RUN - 1));

    assign status.t_ge_rate = (t_reg >= RATE_T);
    assign status.last      = last_now;
    assign status.out_busy  = out_valid_reg && !out_ready;

    // Output register holds a result until the receiver takes it.
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Sample and scaling pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_l_reg <= dec_l;
            smp_r_reg <= dec_r;
        end
        if (cmd.mul)
        begin
            prod_l_reg <= smp_l_reg * $signed({1'b0, cfg.gain_pct});
            prod_r_reg <= smp_r_reg * $signed({1'b0, cfg.gain_pct});
        end
        if (cmd.div)
        begin
            scl_l_reg <= div_sat(prod_l_reg);
            scl_r_reg <= div_sat(prod_r_reg);
        end
        if (cmd.emit)
        begin
            left_reg  <= scl_l_reg;
            right_reg <= scl_r_reg;
            last_reg  <= last_now;
        end
    end

    // Phase accumulator, run counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            t_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                t_reg <= first_frame ? '0 : TACC_W'(phase_reg);
                n_reg <= '0;
            end
            else if (cmd.skip)
            begin
                phase_reg <= PHASE_W'(t_reg - RATE_T);
            end
            else if (cmd.emit)
            begin
                t_reg <= t_sum;
                n_reg <= n_reg + RUN_CNT_W'(1);
                if (last_now)
                begin
                    phase_reg <= sum_ge_rate ? PHASE_W'(t_sum - RATE_T) : '0;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;
    assign last_of_run  = last_reg;

    // A new result never overwrites one the receiver has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten while stalled");

    // Results are only produced while the phase is below the output rate.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (t_reg < RATE_T))
        else $error("emit with phase at or above output rate");

    // Within a run each result advances the counter by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !last_now) |=> (n_reg == $past(n_reg) + RUN_CNT_W'(1)))
        else $error("run counter did not advance");

endmodule

// ----- rtl/audio_rate_format_converter.sv -----
// Audio rate and format converter: one source frame in, zero to 64 stereo frames out.
//
// Input channel (in_valid/in_ready): one source frame in frame_bytes, 8-bit unsigned
// or 16-bit signed, mono or stereo, little-endian, left sample first. first_frame
// clears the phase before the frame is used.
// Output channel (out_valid/out_ready): stereo 16-bit frames at OUTPUT_RATE, chosen
// by floor index mapping, with last_of_run on the final frame caused by a source frame.
// Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index selects source
// rate, stereo, 16-bit and volume percent; write only while the block is idle.
// Timing: a frame is decoded on acceptance, then passes through the volume multiply
// state and the divide-by-100 state with saturation. The run then gives one output
// frame per cycle while the receiver does not stall, and a skipped frame gives none;
// the next frame is accepted in the cycle after its last output is loaded.
// The first output is loaded into the output register in the first step of the run.
// A stalled receiver holds the output register; the run pauses until it drains.
// Reset clears the phase and output valid and loads the default configuration:
// 48000 Hz, stereo, 16-bit, 100 percent volume.
module audio_rate_format_converter
    import arfc_pkg::*;
#(
    parameter int OUTPUT_RATE = 48000
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [RATE_W-1:0]          cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [FRAME_W-1:0]         frame_bytes,
    input  logic                       first_frame,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] left_sample,
    output logic signed [SAMPLE_W-1:0] right_sample,
    output logic                       last_of_run
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers
    arfc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer
    arfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    arfc_datapath #(
        .OUTPUT_RATE (OUTPUT_RATE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .frame_bytes  (frame_bytes),
        .first_frame  (first_frame),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .last_of_run  (last_of_run)
    );

endmodule
